FILE: design/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int MAX_KEY_BYTES = 32;
   localparam int KEY_WORDS     = 4;
   localparam int KEY_WORD_W    = 64;
   localparam int KEY_LEN_W     = 6;
   localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
   localparam int PERM_DEPTH    = 256;
   localparam int IDX_W         = $clog2(PERM_DEPTH);
   localparam int BYTE_W        = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = KEY_WORD_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LEN = 3'd4;

   // datapath operations issued by the controller, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // latch input byte, clear schedule counters
      OP_INIT_WR,   // S[n] = n
      OP_K_RD_N,    // read S[n]
      OP_K_RD_ACC,  // acc += S[n] + key; read S[acc]
      OP_K_WR_N,    // S[n] = S[acc]
      OP_K_WR_ACC,  // S[acc] = old S[n]; advance n and key index
      OP_P_RD_I,    // i++; read S[i]
      OP_P_RD_J,    // j += S[i]; read S[j]
      OP_P_WR_I,    // S[i] = S[j]; read S[S[i] + S[j]]
      OP_P_OUT      // S[j] = old S[i]; register result
   } dp_op_type;

   typedef struct packed {
      logic need_sched;  // accepted beat must run the key schedule first
      logic n_last;      // schedule counter at the final entry
      logic rsp_busy;    // output register holds a beat not yet taken
   } dp_status_type;

endpackage

FILE: design/rc4_if.sv
`timescale 1ns / 1ps

interface rc4_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_message;

   modport source (output valid, output data_byte, output start_of_message, input ready);
   modport sink   (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface rc4_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cipher_byte;

   modport source (output valid, output cipher_byte, input ready);
   modport sink   (input valid, input cipher_byte, output ready);
endinterface

FILE: design/rc4_ctrl.sv
`timescale 1ns / 1ps

module rc4_ctrl
   import rc4_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_op_type     op
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_INIT = 10'b00_0000_0010,
      ST_KRN  = 10'b00_0000_0100,
      ST_KRA  = 10'b00_0000_1000,
      ST_KWN  = 10'b00_0001_0000,
      ST_KWA  = 10'b00_0010_0000,
      ST_PRI  = 10'b00_0100_0000,
      ST_PRJ  = 10'b00_1000_0000,
      ST_PWI  = 10'b01_0000_0000,
      ST_POUT = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = status.need_sched ? ST_INIT : ST_PRI;
            end
         end
         ST_INIT: begin
            op = OP_INIT_WR;
            if (status.n_last) state_in = ST_KRN;
         end
         ST_KRN: begin
            op       = OP_K_RD_N;
            state_in = ST_KRA;
         end
         ST_KRA: begin
            op       = OP_K_RD_ACC;
            state_in = ST_KWN;
         end
         ST_KWN: begin
            op       = OP_K_WR_N;
            state_in = ST_KWA;
         end
         ST_KWA: begin
            op       = OP_K_WR_ACC;
            state_in = status.n_last ? ST_PRI : ST_KRN;
         end
         ST_PRI: begin
            op       = OP_P_RD_I;
            state_in = ST_PRJ;
         end
         ST_PRJ: begin
            op       = OP_P_RD_J;
            state_in = ST_PWI;
         end
         ST_PWI: begin
            op       = OP_P_WR_I;
            state_in = ST_POUT;
         end
         ST_POUT: begin
            // hold until the output register frees up
            if (!status.rsp_busy) begin
               op       = OP_P_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: design/rc4_dp.sv
`timescale 1ns / 1ps

module rc4_dp
   import rc4_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_op_type              op,
   output dp_status_type          status,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_start,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [BYTE_W-1:0]      rsp_byte
);

   // configuration
   logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key_ff, key_in;
   logic [KEY_LEN_W-1:0]                 key_len_ff, key_len_in;

   // permutation memory
   logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_waddr, mem_raddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic [BYTE_W-1:0] rd_ff;

   // schedule and generator state
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic              done_ff, done_in;
   logic [BYTE_W-1:0] sa_ff, sa_in;   // S[n] in schedule, S[i] in generator
   logic [BYTE_W-1:0] sb_ff, sb_in;   // S[j] in generator
   logic [IDX_W-1:0]  t_ff, t_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   logic [KEY_LEN_W-1:0] len_eff;
   logic [KIDX_W-1:0]    kidx_last;
   logic [BYTE_W-1:0]    key_byte;
   logic [BYTE_W-1:0]    ks_byte;

   always_comb begin
      if (key_len_ff == '0)
         len_eff = KEY_LEN_W'(1);
      else if (key_len_ff > KEY_LEN_W'(MAX_KEY_BYTES))
         len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
      else
         len_eff = key_len_ff;
   end

   assign kidx_last = KIDX_W'(len_eff - KEY_LEN_W'(1));
   assign key_byte  = key_ff[kidx_ff[KIDX_W-1:3]][{kidx_ff[2:0], 3'b000} +: BYTE_W];

   // swapped entries are not yet both in memory when S[t] is read
   always_comb begin
      if (t_ff == j_ff)      ks_byte = sa_ff;
      else if (t_ff == i_ff) ks_byte = sb_ff;
      else                   ks_byte = rd_ff;
   end

   always_comb begin
      key_in     = key_ff;
      key_len_in = key_len_ff;
      if (csr_we) begin
         unique case (csr_index) inside
            CSR_KEY_0, CSR_KEY_1, CSR_KEY_2, CSR_KEY_3: key_in[csr_index[1:0]] = csr_wdata;
            CSR_KEY_LEN: key_len_in = csr_wdata[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = n_ff;
      mem_raddr    = n_ff;
      mem_wdata    = rd_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      kidx_in      = kidx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      done_in      = done_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      t_in         = t_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      unique case (op)
         OP_NONE: ;
         OP_LOAD: begin
            data_in = req_data_byte;
            n_in    = '0;
            acc_in  = '0;
            kidx_in = '0;
         end
         OP_INIT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = n_ff;
            mem_wdata = n_ff;
            n_in      = n_ff + IDX_W'(1);
         end
         OP_K_RD_N: begin
            mem_re    = 1'b1;
            mem_raddr = n_ff;
         end
         OP_K_RD_ACC: begin
            acc_in    = acc_ff + rd_ff + key_byte;
            sa_in     = rd_ff;
            mem_re    = 1'b1;
            mem_raddr = acc_in;
         end
         OP_K_WR_N: begin
            mem_we    = 1'b1;
            mem_waddr = n_ff;
            mem_wdata = rd_ff;
         end
         OP_K_WR_ACC: begin
            mem_we    = 1'b1;
            mem_waddr = acc_ff;
            mem_wdata = sa_ff;
            n_in      = n_ff + IDX_W'(1);
            kidx_in   = (kidx_ff == kidx_last) ? '0 : kidx_ff + KIDX_W'(1);
            if (status.n_last) begin
               i_in    = '0;
               j_in    = '0;
               done_in = 1'b1;
            end
         end
         OP_P_RD_I: begin
            i_in      = i_ff + IDX_W'(1);
            mem_re    = 1'b1;
            mem_raddr = i_in;
         end
         OP_P_RD_J: begin
            sa_in     = rd_ff;
            j_in      = j_ff + rd_ff;
            mem_re    = 1'b1;
            mem_raddr = j_in;
         end
         OP_P_WR_I: begin
            sb_in     = rd_ff;
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rd_ff;
            t_in      = sa_ff + rd_ff;
            mem_re    = 1'b1;
            mem_raddr = t_in;
         end
         OP_P_OUT: begin
            mem_we       = 1'b1;
            mem_waddr    = j_ff;
            mem_wdata    = sa_ff;
            rsp_valid_in = 1'b1;
            rsp_byte_in  = data_ff ^ ks_byte;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) perm_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= perm_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         key_len_ff   <= KEY_LEN_W'(1);
         i_ff         <= '0;
         j_ff         <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         key_len_ff   <= key_len_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      acc_ff      <= acc_in;
      kidx_ff     <= kidx_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      t_ff        <= t_in;
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign status.need_sched = req_start | ~done_ff;
   assign status.n_last     = (n_ff == IDX_W'(PERM_DEPTH - 1));
   assign status.rsp_busy   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;

endmodule

FILE: design/rc4_keystream_cipher.sv
`timescale 1ns / 1ps
// A beat passes ST_PRI, ST_PRJ and ST_PWI; ST_POUT registers its result, waiting
// while the output register is full. A new beat is taken only in ST_IDLE. The swap
// is bounded by the single read port and single write port of the 256-entry
// permutation memory. A beat that starts a message (or the first beat after reset)
// first runs the key schedule: identity fill of 256 entries, then 256 mixing steps.
// Reset is synchronous, active high; the permutation memory is not cleared.

module rc4_keystream_cipher
   import rc4_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   rc4_req_if.sink                req_ch,
   rc4_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_op_type     op;
   dp_status_type status;

   rc4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .op        (op)
   );

   rc4_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .status        (status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_data_byte (req_ch.data_byte),
      .req_start     (req_ch.start_of_message),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_byte      (rsp_ch.cipher_byte)
   );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rc4_pkg::*;

   localparam int SETTLE_CYCLES = 8;    // idle margin after the last pending result is checked
   localparam int MAX_GAP       = 40;
   localparam int RANDOM_ITEMS  = 750;
   localparam int PHASES        = 4;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              start_of_message;
   } req_beat_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rc4_req_if req_ch ();
   rc4_rsp_if rsp_ch ();

   rc4_keystream_cipher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and permutation state
   logic [KEY_WORD_W-1:0] key_shadow [KEY_WORDS];
   logic [KEY_LEN_W-1:0]  key_len_shadow;
   logic [BYTE_W-1:0]     sbox [PERM_DEPTH];
   logic [IDX_W-1:0]      sbox_i;
   logic [IDX_W-1:0]      sbox_j;
   logic                  sbox_keyed;

   logic [BYTE_W-1:0] pending_cipher [$];

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int n_sent        = 0;
   int n_checked     = 0;
   int n_rekeys      = 0;
   int n_csr_writes  = 0;
   int n_errors      = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [BYTE_W-1:0] key_byte_at(input int n);
      return key_shadow[n / 8][(n % 8) * BYTE_W +: BYTE_W];
   endfunction

   function automatic void mix_key_into_sbox();
      int                len;
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] tmp;
      len = key_len_shadow;
      if (len == 0) len = 1;
      if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
      for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = BYTE_W'(n);
      acc = '0;
      for (int n = 0; n < PERM_DEPTH; n++) begin
         acc = acc + sbox[n] + key_byte_at(n % len);
         tmp = sbox[n];
         sbox[n] = sbox[acc];
         sbox[acc] = tmp;
      end
      sbox_i = '0;
      sbox_j = '0;
      sbox_keyed = 1'b1;
      n_rekeys++;
   endfunction

   function automatic logic [BYTE_W-1:0] predict_cipher_byte(input req_beat_type beat);
      logic [BYTE_W-1:0] tmp;
      logic [IDX_W-1:0]  pick;
      if (beat.start_of_message || !sbox_keyed) mix_key_into_sbox();
      sbox_i = sbox_i + 1'b1;
      sbox_j = sbox_j + sbox[sbox_i];
      tmp = sbox[sbox_i];
      sbox[sbox_i] = sbox[sbox_j];
      sbox[sbox_j] = tmp;
      pick = sbox[sbox_i] + sbox[sbox_j];
      return beat.data_byte ^ sbox[pick];
   endfunction

   task automatic report_mismatch(input string msg);
      n_errors++;
      $display("tb: mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_cipher.size() == 0) begin
            report_mismatch($sformatf("result %02h with nothing pending", rsp_ch.cipher_byte));
         end else begin
            if (rsp_ch.cipher_byte !== pending_cipher[0]) begin
               report_mismatch($sformatf("result %0d: cipher_byte got %02h, want %02h",
                                         n_checked, rsp_ch.cipher_byte, pending_cipher[0]));
            end
            void'(pending_cipher.pop_front());
            n_checked++;
         end
      end
   end

   // called on a clock edge; leaves valid high so the next beat can follow directly
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic som);
      req_beat_type beat;
      int           gap;
      beat.data_byte = data;
      beat.start_of_message = som;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < req_idle_pct) gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= beat.data_byte;
      req_ch.start_of_message <= beat.start_of_message;
      do @(posedge clock); while (!req_ch.ready);
      pending_cipher.push_back(predict_cipher_byte(beat));
      n_sent++;
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (pending_cipher.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only while idle
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx <= CSR_KEY_3) begin
         key_shadow[idx] = data;
      end else if (idx == CSR_KEY_LEN) begin
         key_len_shadow = data[KEY_LEN_W-1:0];
      end
      n_csr_writes++;
      @(posedge clock);
   endtask

   task automatic write_key_words(input logic [KEY_WORD_W-1:0] w0, input logic [KEY_WORD_W-1:0] w1,
                                  input logic [KEY_WORD_W-1:0] w2, input logic [KEY_WORD_W-1:0] w3);
      csr_write(CSR_KEY_0, w0);
      csr_write(CSR_KEY_1, w1);
      csr_write(CSR_KEY_2, w2);
      csr_write(CSR_KEY_3, w3);
   endtask

   task automatic randomize_key();
      logic [CSR_DATA_W-1:0] word;
      int                    pick;
      int                    len;
      wait_for_results();
      for (int w = 0; w < KEY_WORDS; w++) begin
         pick = $urandom_range(9);
         word = {$urandom, $urandom};
         if (pick == 0) word = '0;
         if (pick == 1) word = '1;
         if (pick < 7) csr_write(CSR_INDEX_W'(w), word);
      end
      pick = $urandom_range(99);
      if (pick < 5)       len = 0;
      else if (pick < 12) len = $urandom_range(MAX_KEY_BYTES + 1, 2**KEY_LEN_W - 1);
      else if (pick < 20) len = MAX_KEY_BYTES;
      else if (pick < 25) len = 1;
      else                len = $urandom_range(1, MAX_KEY_BYTES);
      word = {$urandom, $urandom};
      word[KEY_LEN_W-1:0] = KEY_LEN_W'(len);
      csr_write(CSR_KEY_LEN, word);
      if ($urandom_range(7) == 0)
         csr_write(CSR_INDEX_W'($urandom_range(CSR_KEY_LEN + 1, 2**CSR_INDEX_W - 1)),
                   {$urandom, $urandom});
   endtask

   // no start flag on the first beat: the schedule must still run with reset key values
   task automatic test_first_beat_after_reset();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
   endtask

   task automatic test_key_extremes();
      wait_for_results();
      write_key_words('1, '1, '1, '1);
      csr_write(CSR_KEY_LEN, CSR_DATA_W'(MAX_KEY_BYTES));
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      wait_for_results();
      write_key_words('0, '0, '0, '0);
      csr_write(CSR_KEY_LEN, CSR_DATA_W'(1));
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
   endtask

   task automatic test_zero_key_length();
      wait_for_results();
      csr_write(CSR_KEY_0, 64'h0123_4567_89AB_CDEF);
      csr_write(CSR_KEY_LEN, '0);
      send_byte(8'h3C, 1'b1);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   task automatic test_oversized_key_length();
      wait_for_results();
      write_key_words({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      csr_write(CSR_KEY_LEN, CSR_DATA_W'(2**KEY_LEN_W - 1));
      send_byte(8'h81, 1'b1);
      send_byte(8'h7E, 1'b0);
      wait_for_results();
      csr_write(CSR_KEY_LEN, CSR_DATA_W'(MAX_KEY_BYTES + 1));
      send_byte(8'h10, 1'b1);
      send_byte(8'h01, 1'b0);
   endtask

   // new key lands only at the next start of message
   task automatic test_key_change_mid_message();
      wait_for_results();
      csr_write(CSR_KEY_LEN, CSR_DATA_W'(16));
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b0);
      wait_for_results();
      write_key_words({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      csr_write(CSR_KEY_LEN, CSR_DATA_W'(5));
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b0);
      send_byte(8'h55, 1'b1);
   endtask

   task automatic test_unknown_register();
      wait_for_results();
      for (int k = CSR_KEY_LEN + 1; k < 2**CSR_INDEX_W; k++)
         csr_write(CSR_INDEX_W'(k), {$urandom, $urandom});
      send_byte(8'h66, 1'b1);
      send_byte(8'h99, 1'b0);
   endtask

   task automatic test_random_traffic();
      int quota;
      int sent_here;
      int msg_len;
      quota = RANDOM_ITEMS / PHASES;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin req_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         sent_here = 0;
         while (sent_here < quota) begin
            if ($urandom_range(3) == 0) randomize_key();
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
            for (int b = 0; b < msg_len; b++) begin
               if (b > 0 && $urandom_range(29) == 0) randomize_key();
               // mostly clean messages; a stray start flag now and then
               send_byte(BYTE_W'($urandom), (b == 0) || ($urandom_range(19) == 0));
               sent_here++;
            end
            if ($urandom_range(9) == 0) wait_for_results();
         end
      end
      req_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.start_of_message = 1'b0;
      rsp_ch.ready = 1'b0;
      for (int w = 0; w < KEY_WORDS; w++) key_shadow[w] = '0;
      key_len_shadow = KEY_LEN_W'(1);
      sbox_i = '0;
      sbox_j = '0;
      sbox_keyed = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_beat_after_reset();
      test_key_extremes();
      test_zero_key_length();
      test_oversized_key_length();
      test_key_change_mid_message();
      test_unknown_register();
      test_random_traffic();
      wait_for_results();

      $display("tb: %0d bytes sent, %0d checked, %0d key schedules, %0d register writes",
               n_sent, n_checked, n_rekeys, n_csr_writes);
      $display("tb: key lengths 0 to 63, all-zero and all-one keys, four idle/stall mixes");
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
